// ----- src/rlwq_pkg.sv -----
// ---------------------------------------------------------------------------
// rlwq_pkg: shared definitions for the recursive lock with wait queue
// Widths, queue sizing, command and status codes, queue status and control bundles.
// ---------------------------------------------------------------------------
package rlwq_pkg;

   // thread id and queue sizing
   localparam int ID_BITS     = 8;
   localparam int THREAD_W    = 8;
   localparam int WAIT_DEPTH  = 16;
   localparam int PTR_W       = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
   localparam int FILL_W      = $clog2(WAIT_DEPTH + 1);
   localparam int DEPTH_W     = 8;

   localparam logic [THREAD_W-1:0] ID_MASK =
      (ID_BITS >= THREAD_W) ? {THREAD_W{1'b1}} : THREAD_W'((1 << ID_BITS) - 1);
   localparam logic [DEPTH_W-1:0]  DEPTH_MAX = {DEPTH_W{1'b1}};

   // request commands
   localparam logic CMD_ACQUIRE = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   // response status codes
   localparam logic [2:0] ST_GRANTED    = 3'd0;
   localparam logic [2:0] ST_BLOCKED    = 3'd1;
   localparam logic [2:0] ST_FREED      = 3'd2;
   localparam logic [2:0] ST_NESTED_REL = 3'd3;
   localparam logic [2:0] ST_QUEUE_OVF  = 3'd4;
   localparam logic [2:0] ST_DEPTH_OVF  = 3'd5;
   localparam logic [2:0] ST_FREE_REL   = 3'd6;

   // wait queue status seen by the lock logic
   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   // wait queue controls from the lock logic
   typedef struct packed {
      logic push;
      logic pop;
   } queue_ctrl_type;

endpackage

// ----- src/recursive_lock_with_wait_queue_top.sv -----
// ---------------------------------------------------------------------------
// recursive_lock_with_wait_queue_top: recursive lock with FIFO wait queue
// Holder, nest depth and wait queue updated once per request transfer.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready): req_cmd selects acquire or
//   release, req_thread_id names the requesting thread.
//   Response channel (rsp_valid/rsp_ready): one response per request with
//   status, the thread woken by a release (if any), and the holder and nest
//   depth after the request.
//   The response is registered and appears the cycle after the request
//   transfer. One request per cycle while responses are taken; the lock
//   state, holder register and at most one queue entry update in that cycle.
//   req_ready is high while the response register is empty or is being
//   taken in the same cycle, so a stalled receiver holds the response and
//   stops further requests, with no loss.
//   Reset: synchronous; the lock is free, depth 0, the wait queue empty and
//   no response pending. Queue entries are not cleared.
//   The semaphore count is implied: 1 - holder valid - queue fill.
// ---------------------------------------------------------------------------
module recursive_lock_with_wait_queue_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_cmd,
   input  logic [rlwq_pkg::THREAD_W-1:0]  req_thread_id,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [2:0]                     rsp_status,
   output logic                           rsp_woken_valid,
   output logic [rlwq_pkg::THREAD_W-1:0]  rsp_woken_thread,
   output logic                           rsp_holder_valid,
   output logic [rlwq_pkg::THREAD_W-1:0]  rsp_holder_thread,
   output logic [rlwq_pkg::DEPTH_W-1:0]   rsp_nest_depth
);
   import rlwq_pkg::*;

   logic                owner_valid_ff, owner_valid_in;
   logic [THREAD_W-1:0] owner_id_ff, owner_id_in;
   logic [DEPTH_W-1:0]  depth_ff, depth_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [2:0]          status_ff, status_in;
   logic                woken_valid_ff, woken_valid_in;
   logic [THREAD_W-1:0] woken_id_ff, woken_id_in;

   logic                accept;
   logic [THREAD_W-1:0] tid;
   logic [THREAD_W-1:0] head_id;
   queue_stat_type      qstat;
   queue_ctrl_type      qctrl;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign tid       = req_thread_id & ID_MASK;

   // wait queue of blocked threads
   rlwq_wait_queue u_wait_queue (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (qctrl),
      .push_id (tid),
      .head_id (head_id),
      .stat    (qstat)
   );

   // lock decision for the request in transfer
   always_comb begin
      owner_valid_in = owner_valid_ff;
      owner_id_in    = owner_id_ff;
      depth_in       = depth_ff;
      status_in      = status_ff;
      woken_valid_in = woken_valid_ff;
      woken_id_in    = woken_id_ff;
      qctrl          = '0;
      if (accept) begin
         woken_valid_in = 1'b0;
         woken_id_in    = '0;
         unique case (req_cmd)
            CMD_ACQUIRE: begin
               priority if (owner_valid_ff && owner_id_ff == tid) begin
                  if (depth_ff == DEPTH_MAX) begin
                     status_in = ST_DEPTH_OVF;
                  end else begin
                     depth_in  = depth_ff + DEPTH_W'(1);
                     status_in = ST_GRANTED;
                  end
               end else if (owner_valid_ff || !qstat.empty) begin
                  if (qstat.full) begin
                     status_in = ST_QUEUE_OVF;
                  end else begin
                     qctrl.push = 1'b1;
                     status_in  = ST_BLOCKED;
                  end
               end else begin
                  owner_valid_in = 1'b1;
                  owner_id_in    = tid;
                  depth_in       = DEPTH_W'(1);
                  status_in      = ST_GRANTED;
               end
            end
            CMD_RELEASE: begin
               priority if (!owner_valid_ff) begin
                  status_in = ST_FREE_REL;
               end else if (depth_ff > DEPTH_W'(1)) begin
                  depth_in  = depth_ff - DEPTH_W'(1);
                  status_in = ST_NESTED_REL;
               end else begin
                  status_in = ST_FREED;
                  if (!qstat.empty) begin
                     // hand over to the oldest waiter
                     qctrl.pop      = 1'b1;
                     woken_valid_in = 1'b1;
                     woken_id_in    = head_id;
                     owner_valid_in = 1'b1;
                     owner_id_in    = head_id;
                     depth_in       = DEPTH_W'(1);
                  end else begin
                     owner_valid_in = 1'b0;
                     owner_id_in    = '0;
                     depth_in       = '0;
                  end
               end
            end
            default: begin
               status_in = status_ff;
            end
         endcase
      end
   end

   // response register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   // lock state and response control
   always_ff @(posedge clock) begin
      if (reset) begin
         owner_valid_ff <= 1'b0;
         owner_id_ff    <= '0;
         depth_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         owner_valid_ff <= owner_valid_in;
         owner_id_ff    <= owner_id_in;
         depth_ff       <= depth_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      status_ff      <= status_in;
      woken_valid_ff <= woken_valid_in;
      woken_id_ff    <= woken_id_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_woken_valid   = woken_valid_ff;
   assign rsp_woken_thread  = woken_id_ff;
   assign rsp_holder_valid  = owner_valid_ff;
   assign rsp_holder_thread = owner_id_ff;
   assign rsp_nest_depth    = depth_ff;

endmodule

// ----- src/rlwq_wait_queue.sv -----
// ---------------------------------------------------------------------------
// rlwq_wait_queue: FIFO of blocked thread ids
// Circular buffer with head, tail and fill count; oldest id shown at head.
// ---------------------------------------------------------------------------
module rlwq_wait_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  rlwq_pkg::queue_ctrl_type        ctrl,
   input  logic [rlwq_pkg::THREAD_W-1:0]   push_id,
   output logic [rlwq_pkg::THREAD_W-1:0]   head_id,
   output rlwq_pkg::queue_stat_type        stat
);
   import rlwq_pkg::*;

   logic [THREAD_W-1:0] entry_ff [WAIT_DEPTH];
   logic [PTR_W-1:0]    head_ff, head_in;
   logic [PTR_W-1:0]    tail_ff, tail_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;

   // pointer advance with wrap at the queue depth
   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(WAIT_DEPTH - 1)) r = '0;
      else r = p + PTR_W'(1);
      return r;
   endfunction

   assign head_id    = entry_ff[head_ff];
   assign stat.full  = (fill_ff == FILL_W'(WAIT_DEPTH));
   assign stat.empty = (fill_ff == '0);

   // next pointers and fill count; push and pop never coincide
   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      if (ctrl.push) begin
         tail_in = ptr_next(tail_ff);
         fill_in = fill_ff + FILL_W'(1);
      end else if (ctrl.pop) begin
         head_in = ptr_next(head_ff);
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

   // entry storage, undefined until written
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         entry_ff[tail_ff] <= push_id;
      end
   end

endmodule

// ----- verif/tb_recursive_lock_with_wait_queue_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_recursive_lock_with_wait_queue_top: recursive lock self-checking bench
// A short directed pass covers release while free, nesting, blocking,
// requeueing, queue overflow, a release by a non-holder and a hand-over.
// Random sequences of contention, nesting, draining, deep nesting up to
// depth saturation, and noise then follow under several idle and stall
// profiles. A lock tracker predicts every response and checks each one.
// ---------------------------------------------------------------------------
module tb_recursive_lock_with_wait_queue_top;
   import rlwq_pkg::*;

   typedef struct packed {
      logic [2:0]          status;
      logic                woken_valid;
      logic [THREAD_W-1:0] woken_thread;
      logic                holder_valid;
      logic [THREAD_W-1:0] holder_thread;
      logic [DEPTH_W-1:0]  nest_depth;
   } lock_rsp_type;

   // lock tracker: predicted lock state and the responses still to come
   class lock_tracker;
      bit                  holder_valid;
      logic [THREAD_W-1:0] holder_id;
      int                  depth;
      int                  sem_count;
      logic [THREAD_W-1:0] waiters[$];
      lock_rsp_type        expected_rsps[$];
      int                  failures;

      function new();
         holder_valid = 1'b0;
         holder_id    = '0;
         depth        = 0;
         sem_count    = 1;
         failures     = 0;
      endfunction

      // work out the response to an accepted request
      function void note_request(input logic cmd, input logic [THREAD_W-1:0] tid_in);
         lock_rsp_type        r;
         logic [THREAD_W-1:0] tid;
         tid = tid_in & ID_MASK;
         r   = '0;
         if (cmd == CMD_ACQUIRE) begin
            if (holder_valid && holder_id == tid) begin
               if (depth >= int'(DEPTH_MAX)) begin
                  r.status = ST_DEPTH_OVF;
               end else begin
                  depth++;
                  r.status = ST_GRANTED;
               end
            end else if (sem_count - 1 < 0) begin
               if (waiters.size() >= WAIT_DEPTH) begin
                  r.status = ST_QUEUE_OVF;
               end else begin
                  sem_count--;
                  waiters.push_back(tid);
                  r.status = ST_BLOCKED;
               end
            end else begin
               sem_count--;
               holder_valid = 1'b1;
               holder_id    = tid;
               depth        = 1;
               r.status     = ST_GRANTED;
            end
         end else begin
            if (!holder_valid) begin
               r.status = ST_FREE_REL;
            end else if (depth > 1) begin
               depth--;
               r.status = ST_NESTED_REL;
            end else begin
               holder_valid = 1'b0;
               holder_id    = '0;
               depth        = 0;
               sem_count++;
               // hand the lock to the oldest waiter
               if (sem_count <= 0 && waiters.size() > 0) begin
                  r.woken_valid  = 1'b1;
                  r.woken_thread = waiters.pop_front();
                  holder_valid   = 1'b1;
                  holder_id      = r.woken_thread;
                  depth          = 1;
               end
               r.status = ST_FREED;
            end
         end
         r.holder_valid  = holder_valid;
         r.holder_thread = holder_valid ? holder_id : '0;
         r.nest_depth    = holder_valid ? DEPTH_W'(depth) : '0;
         expected_rsps.push_back(r);
      endfunction

      function void compare_field(input string name, input int exp_val, input int act_val);
         if (exp_val != act_val) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_val, act_val);
            failures++;
         end
      endfunction

      // compare a response transfer with the oldest prediction
      function void check_response(input lock_rsp_type act);
         lock_rsp_type exp;
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual status %0d",
                     $time, act.status);
            failures++;
            return;
         end
         exp = expected_rsps.pop_front();
         compare_field("status", exp.status, act.status);
         compare_field("woken_valid", exp.woken_valid, act.woken_valid);
         compare_field("woken_thread", exp.woken_thread, act.woken_thread);
         compare_field("holder_valid", exp.holder_valid, act.holder_valid);
         compare_field("holder_thread", exp.holder_thread, act.holder_thread);
         compare_field("nest_depth", exp.nest_depth, act.nest_depth);
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic                req_cmd;
   logic [THREAD_W-1:0] req_thread_id;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [2:0]          rsp_status;
   logic                rsp_woken_valid;
   logic [THREAD_W-1:0] rsp_woken_thread;
   logic                rsp_holder_valid;
   logic [THREAD_W-1:0] rsp_holder_thread;
   logic [DEPTH_W-1:0]  rsp_nest_depth;

   lock_tracker         sb = new();
   int                  req_idle_pct;
   int                  rsp_stall_pct;
   int                  items_sent;
   logic [THREAD_W-1:0] id_pool[8];

   recursive_lock_with_wait_queue_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_thread_id     (req_thread_id),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_woken_valid   (rsp_woken_valid),
      .rsp_woken_thread  (rsp_woken_thread),
      .rsp_holder_valid  (rsp_holder_valid),
      .rsp_holder_thread (rsp_holder_thread),
      .rsp_nest_depth    (rsp_nest_depth)
   );

   // clock generation
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // overall time limit
   initial begin
      #5000000;
      $display("Test completed with failures");
      $finish;
   end

   // receiver: random stalls, changed at the falling edge
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // response transfers checked at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_response({rsp_status, rsp_woken_valid, rsp_woken_thread,
                            rsp_holder_valid, rsp_holder_thread, rsp_nest_depth});
      end
   end

   // one request transfer; entered and left at a falling edge
   task automatic send_request(input logic cmd, input logic [THREAD_W-1:0] tid);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_thread_id <= tid;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(cmd, tid);
      items_sent++;
      @(negedge clock);
   endtask

   // mostly a small set of threads so that holders and waiters recur
   function automatic logic [THREAD_W-1:0] pick_tid();
      if ($urandom_range(0, 3) == 0) begin
         return THREAD_W'($urandom_range(0, 255));
      end
      return id_pool[$urandom_range(0, 7)];
   endfunction

   // random sequences until the phase has sent its share
   task automatic run_random_phase(input int quota, input bit start_deep);
      int                  start;
      int                  roll;
      int                  n;
      bit                  first;
      logic [THREAD_W-1:0] tid;
      start = items_sent;
      first = start_deep;
      while (items_sent - start < quota) begin
         roll  = first ? 0 : $urandom_range(0, 99);
         first = 1'b0;
         if (roll < 2) begin
            // deep nesting up to depth saturation, then unwind
            tid = sb.holder_valid ? sb.holder_id : pick_tid();
            repeat ($urandom_range(250, 262)) send_request(CMD_ACQUIRE, tid);
            repeat ($urandom_range(240, 262)) send_request(CMD_RELEASE, tid);
         end else if (roll < 37) begin
            // contention: many threads ask for the lock
            n = $urandom_range(1, 24);
            repeat (n) send_request(CMD_ACQUIRE, pick_tid());
         end else if (roll < 62) begin
            // holder nests and then unwinds, sometimes by another thread
            tid = sb.holder_valid ? sb.holder_id : pick_tid();
            n   = $urandom_range(1, 6);
            repeat (n) send_request(CMD_ACQUIRE, tid);
            repeat ($urandom_range(0, n + 1)) begin
               send_request(CMD_RELEASE, ($urandom_range(0, 4) == 0) ? pick_tid() : tid);
            end
         end else if (roll < 87) begin
            // drain: releases hand the lock down the queue
            repeat ($urandom_range(1, 8)) begin
               send_request(CMD_RELEASE,
                  (sb.holder_valid && $urandom_range(0, 4) != 0) ? sb.holder_id : pick_tid());
            end
         end else begin
            // noise
            repeat ($urandom_range(1, 10)) begin
               send_request(1'($urandom_range(0, 1)), THREAD_W'($urandom_range(0, 255)));
            end
         end
      end
   endtask

   // stimulus and end of run
   initial begin
      int wait_cycles;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_cmd       <= CMD_ACQUIRE;
      req_thread_id <= '0;
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      items_sent    = 0;
      id_pool[0]    = 8'h00;
      id_pool[1]    = 8'hFF;
      for (int i = 2; i < 8; i++) id_pool[i] = THREAD_W'($urandom_range(0, 255));
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: release while free, grant, nest
      send_request(CMD_RELEASE, 8'h00);
      send_request(CMD_ACQUIRE, 8'h00);
      send_request(CMD_ACQUIRE, 8'h00);
      // fill the wait queue, one thread queued twice
      send_request(CMD_ACQUIRE, 8'hFF);
      send_request(CMD_ACQUIRE, 8'hAA);
      send_request(CMD_ACQUIRE, 8'hFF);
      for (int i = 1; i <= WAIT_DEPTH - 3; i++) send_request(CMD_ACQUIRE, THREAD_W'(i * 17));
      // queue full
      send_request(CMD_ACQUIRE, 8'h55);
      // release by a thread other than the holder, then hand-over
      send_request(CMD_RELEASE, 8'h55);
      send_request(CMD_RELEASE, 8'h00);
      send_request(CMD_ACQUIRE, 8'hFF);

      // random phases under different idle and stall profiles
      run_random_phase(406, 1'b1);
      req_idle_pct  = 87;
      rsp_stall_pct = 0;
      run_random_phase(406, 1'b0);
      req_idle_pct  = 0;
      rsp_stall_pct = 87;
      run_random_phase(406, 1'b0);
      req_idle_pct  = 10;
      rsp_stall_pct = 10;
      run_random_phase(406, 1'b1);
      req_valid <= 1'b0;

      // wait for outstanding responses, then report the result
      wait_cycles = 0;
      while (sb.expected_rsps.size() != 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (4) @(posedge clock);
      if (sb.expected_rsps.size() != 0) begin
         $display("%0t: missing responses, expected %0d more, actual 0",
                  $time, sb.expected_rsps.size());
         sb.failures++;
      end
      if (sb.failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
